// ===== rtl/core/oer_pkg.sv =====
package oer_pkg;

    localparam int CMD_W  = 2;
    localparam int TYPE_W = 8;
    localparam int TIME_W = 32;
    localparam int ID_W   = 32;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 6;
    localparam int CNT_W  = 6;
    localparam int SLOT_W = TYPE_W + TIME_W;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_RECOVER = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_AHEAD = 2'd2,
        STAT_STALE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_SCAN_FIN
    } state_t;

endpackage

// ===== rtl/core/oer_ram.sv =====
module oer_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/overwriting_event_ring_with_ids_top.sv =====
// Push, peek and remove: the result strobe shows in the cycle after acceptance. Recover reads every
// slot in use, one slot read per cycle in the scan state, then passes the scan tail and fin states.
// Throughput: push, peek and remove one word per cycle while idle; recover holds busy until its result.
// Reset: asynchronous, active low; the slot store is then cleared, one slot per cycle,
// with busy high. The receiver cannot stall; each result shows for one cycle.
module overwriting_event_ring_with_ids_top #(
    parameter int DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [oer_pkg::CMD_W-1:0]   cmd,
    input  logic [oer_pkg::TYPE_W-1:0]  event_type,
    input  logic [oer_pkg::TIME_W-1:0]  event_time,
    input  logic [oer_pkg::ID_W-1:0]    remove_id,
    input  logic                        cfg_we,
    input  logic [oer_pkg::CFG_W-1:0]   cfg_data,
    output logic                        done,
    output logic [oer_pkg::STAT_W-1:0]  status,
    output logic [oer_pkg::TYPE_W-1:0]  out_type,
    output logic [oer_pkg::TIME_W-1:0]  out_time,
    output logic [oer_pkg::ID_W-1:0]    out_id,
    output logic [oer_pkg::CNT_W-1:0]   event_count
);

    import oer_pkg::*;

    // Slot index width, and a wider width for sizes and counts that can reach DEPTH.
    localparam int IW = $clog2(DEPTH);
    localparam int XW = ((IW > CFG_W) ? IW : CFG_W) + 1;
    localparam logic [XW-1:0] DEPTH_X  = XW'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    // Advance a ring pointer, wrapping at the size in use.
    function automatic logic [XW-1:0] bump_x(input logic [XW-1:0] idx,
                                             input logic [XW-1:0] sz);
        logic [XW-1:0] n;
        n = idx + 1'b1;
        return (n >= sz) ? '0 : n;
    endfunction

    // Events held, from the pointer pair and the full flag.
    function automatic logic [XW-1:0] count_of(input logic [XW-1:0] oldp,
                                               input logic [XW-1:0] newp,
                                               input logic          full,
                                               input logic [XW-1:0] sz);
        logic [XW-1:0] c;
        if (full)
            c = sz;
        else if (newp >= oldp)
            c = newp - oldp;
        else
            c = sz - oldp + newp;
        return c;
    endfunction

    // Control and ring state
    state_t             state_reg, state_next;
    logic [XW-1:0]      cfg_reg;
    logic [IW-1:0]      old_reg;
    logic [IW-1:0]      nxt_reg;
    logic               full_reg;
    logic [ID_W-1:0]    newest_reg;
    logic [IW-1:0]      clr_reg;

    // Recovery scan state
    logic [IW-1:0]      scan_reg;
    logic               proc_v_reg;
    logic [IW-1:0]      proc_idx_reg;
    logic               prev_reg;
    logic               head_reg;
    logic               tail_reg;
    logic               any_reg;
    logic [TIME_W-1:0]  min_time_reg;
    logic [IW-1:0]      min_at_reg;

    // Result word
    logic               done_reg;
    status_t            status_reg;
    logic               peek_reg;

    // Slot store port
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [SLOT_W-1:0]  ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [SLOT_W-1:0]  ram_rdata;
    logic [TYPE_W-1:0]  rd_type;
    logic [TIME_W-1:0]  rd_time;

    // Derived values
    cmd_t               cmd_c;
    logic               accept;
    logic [XW-1:0]      size_x;
    logic [XW-1:0]      old_x;
    logic [XW-1:0]      nxt_x;
    logic [XW-1:0]      cur_count;
    logic [ID_W-1:0]    first_id;
    logic               ring_empty;
    logic [XW-1:0]      push_old_x;
    logic [XW-1:0]      push_nxt_x;
    logic               push_full;
    logic               rm_match;
    logic               scan_last;
    logic               slot_valid;
    logic               fin_full;
    logic [IW-1:0]      fin_old;
    logic [IW-1:0]      fin_nxt;
    logic [XW-1:0]      fin_count;

    oer_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_c   = cmd_t'(cmd);
    assign rd_type = ram_rdata[SLOT_W-1:TIME_W];
    assign rd_time = ram_rdata[TIME_W-1:0];

    // Size in use: zero acts as one, anything beyond the built depth as the depth.
    always_comb
    begin
        if (cfg_reg == '0)
            size_x = XW'(1);
        else if (cfg_reg > DEPTH_X)
            size_x = DEPTH_X;
        else
            size_x = cfg_reg;
    end

    assign old_x      = XW'(old_reg);
    assign nxt_x      = XW'(nxt_reg);
    assign cur_count  = count_of(old_x, nxt_x, full_reg, size_x);
    assign first_id   = newest_reg + ID_W'(1) - ID_W'(cur_count);
    assign ring_empty = (old_reg == nxt_reg) && !full_reg;
    assign accept     = start && (state_reg == ST_IDLE);

    // Push: drop the oldest when full, then advance the write pointer.
    assign push_old_x = full_reg ? bump_x(old_x, size_x) : old_x;
    assign push_nxt_x = bump_x(nxt_x, size_x);
    assign push_full  = full_reg || (push_nxt_x == push_old_x);
    assign rm_match   = (remove_id == first_id);

    assign scan_last  = (XW'(scan_reg) == (size_x - XW'(1)));
    assign slot_valid = (rd_type != '0) && (rd_time != '0);

    // Without any run boundary but with some event, the ring is full and starts at the
    // earliest timestamp.
    assign fin_full  = !head_reg && !tail_reg && any_reg;
    assign fin_old   = fin_full ? min_at_reg : old_reg;
    assign fin_nxt   = fin_full ? min_at_reg : nxt_reg;
    assign fin_count = count_of(XW'(fin_old), XW'(fin_nxt), fin_full, size_x);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept && (cmd_c == CMD_RECOVER))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_SCAN_TAIL;
            end
            ST_SCAN_TAIL:
            begin
                state_next = ST_SCAN_FIN;
            end
            ST_SCAN_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine: busy and the slot store port
    always_comb
    begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = nxt_reg;
        ram_wdata = '0;
        ram_raddr = old_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (accept && (cmd_c == CMD_PUSH))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = nxt_reg;
                    ram_wdata = {event_type, event_time};
                end
                else if (accept && (cmd_c == CMD_REMOVE) && !ring_empty && rm_match)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = old_reg;
                end
            end
            ST_SCAN:
            begin
                ram_raddr = scan_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cfg_reg      <= DEPTH_X;
            old_reg      <= '0;
            nxt_reg      <= '0;
            full_reg     <= 1'b0;
            newest_reg   <= '0;
            clr_reg      <= '0;
            scan_reg     <= '0;
            proc_v_reg   <= 1'b0;
            proc_idx_reg <= '0;
            prev_reg     <= 1'b0;
            head_reg     <= 1'b0;
            tail_reg     <= 1'b0;
            any_reg      <= 1'b0;
            min_time_reg <= TIME_MAX;
            min_at_reg   <= '0;
            done_reg     <= 1'b0;
            status_reg   <= STAT_OK;
            peek_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= 1'b0;
            peek_reg     <= 1'b0;
            proc_v_reg   <= (state_reg == ST_SCAN);
            proc_idx_reg <= scan_reg;

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd_c)
                            CMD_PUSH:
                            begin
                                old_reg    <= IW'(push_old_x);
                                nxt_reg    <= IW'(push_nxt_x);
                                full_reg   <= push_full;
                                newest_reg <= newest_reg + ID_W'(1);
                                done_reg   <= 1'b1;
                                status_reg <= STAT_OK;
                            end
                            CMD_PEEK:
                            begin
                                // the store is read at the oldest slot on this edge
                                done_reg   <= 1'b1;
                                status_reg <= ring_empty ? STAT_EMPTY : STAT_OK;
                                peek_reg   <= !ring_empty;
                            end
                            CMD_REMOVE:
                            begin
                                done_reg <= 1'b1;
                                if (ring_empty)
                                    status_reg <= STAT_EMPTY;
                                else if (remove_id > first_id)
                                    status_reg <= STAT_AHEAD;
                                else if (remove_id < first_id)
                                    status_reg <= STAT_STALE;
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    full_reg   <= 1'b0;
                                    old_reg    <= IW'(bump_x(old_x, size_x));
                                end
                            end
                            CMD_RECOVER:
                            begin
                                old_reg      <= '0;
                                nxt_reg      <= '0;
                                full_reg     <= 1'b0;
                                scan_reg     <= '0;
                                prev_reg     <= 1'b0;
                                head_reg     <= 1'b0;
                                tail_reg     <= 1'b0;
                                any_reg      <= 1'b0;
                                min_time_reg <= TIME_MAX;
                                min_at_reg   <= '0;
                            end
                            default:
                            begin
                                done_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                ST_SCAN_FIN:
                begin
                    old_reg    <= fin_old;
                    nxt_reg    <= fin_nxt;
                    full_reg   <= fin_full;
                    newest_reg <= ID_W'(fin_count);
                    done_reg   <= 1'b1;
                    status_reg <= STAT_OK;
                end
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase

            // Scan each slot word in the cycle after its read: mark run starts and ends,
            // track the earliest timestamp.
            if (proc_v_reg)
            begin
                if (!slot_valid)
                begin
                    if (prev_reg)
                    begin
                        tail_reg <= 1'b1;
                        nxt_reg  <= proc_idx_reg;
                    end
                    prev_reg <= 1'b0;
                end
                else
                begin
                    if (!prev_reg && (proc_idx_reg != '0))
                    begin
                        head_reg <= 1'b1;
                        old_reg  <= proc_idx_reg;
                    end
                    if (!any_reg || (rd_time < min_time_reg))
                    begin
                        min_time_reg <= rd_time;
                        min_at_reg   <= proc_idx_reg;
                    end
                    any_reg  <= 1'b1;
                    prev_reg <= 1'b1;
                end
            end

            // A size change drops the pointers; store and id counter stay.
            if (cfg_we)
            begin
                cfg_reg  <= XW'(cfg_data);
                old_reg  <= '0;
                nxt_reg  <= '0;
                full_reg <= 1'b0;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_type    = peek_reg ? rd_type : '0;
    assign out_time    = peek_reg ? rd_time : '0;
    assign out_id      = first_id;
    assign event_count = CNT_W'(cur_count);

endmodule

// ===== rtl/core/oer_sva.sv =====
module oer_sva (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [oer_pkg::CMD_W-1:0]   cmd,
    input logic                        done,
    input logic [oer_pkg::STAT_W-1:0]  status,
    input logic [oer_pkg::TYPE_W-1:0]  out_type,
    input logic [oer_pkg::TIME_W-1:0]  out_time,
    input logic [oer_pkg::CNT_W-1:0]   event_count
);

    import oer_pkg::*;

    // Push, peek and remove answer on the very next cycle.
    a_quick_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd != CMD_RECOVER)) |=> done)
        else $error("no result one cycle after a short command");

    // A push never fails.
    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_PUSH)) |=> (status == STAT_OK))
        else $error("push reported a failure");

    // The block is ready again whenever a result is shown.
    a_ready_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // Only a successful peek carries event data; an empty ring holds no events.
    a_data_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_OK)) |-> ((out_type == '0) && (out_time == '0)))
        else $error("event data on a failed command");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_EMPTY)) |-> (event_count == '0))
        else $error("empty status with events held");

endmodule

bind overwriting_event_ring_with_ids_top oer_sva u_oer_sva (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .status      (status),
    .out_type    (out_type),
    .out_time    (out_time),
    .event_count (event_count)
);
